// File: rtl/wtg_pkg.sv
// Shared types and constants for the window tile generator.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package wtg_pkg;

    // Sizes of the axis tables and coordinate fields.
    localparam int MAX_AXES   = 9;
    localparam int AXIS_BITS  = 4;
    localparam int COORD_BITS = 31;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 104;
    localparam int PROD_BITS  = 2 * COORD_BITS;

    // Input command codes carried on the slave tuser.
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_NEXT    = 2'd2;

    // Result status codes carried on the master tuser.
    localparam logic [1:0] STAT_TILE     = 2'd0;
    localparam logic [1:0] STAT_FINISHED = 2'd1;
    localparam logic [1:0] STAT_ACCEPTED = 2'd2;
    localparam logic [1:0] STAT_REJECTED = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_MUL,
        S_LD_CHK,
        S_NX_CHK,
        S_EMIT,
        S_UPD_NIN,
        S_UPD_MUL,
        S_UPD_ADD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the input item, clear the axis counter
        logic rewind;     // rewind the walk
        logic ld_mul;     // multiply stride by count minus one
        logic ld_commit;  // check the load, write tables, emit the answer
        logic fin_emit;   // emit a finished item
        logic tile_emit;  // emit the tile item of the current axis
        logic nin_load;   // latch the tile count of the current axis
        logic upd_mul;    // multiply tile count by stride
        logic upd_apply;  // advance the current axis
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // the output register can take an item
        logic walk_empty;  // empty window or walk already finished
        logic idx_last;    // current axis is the highest active axis
        logic carry;       // current axis wrapped around
    } stat_t;

endpackage

// File: rtl/window_tile_generator.sv
// Window tile generator: cuts a strided multi-axis window into tiles.
// Slave stream: tuser = command, tdata = axis settings of a load.
// Master stream: tuser = status, tdata = tile description, tlast = last item.
// Configuration channel: one write-only register, the number of active axes.
// A load is checked after it is accepted: the multiplier state forms the
// product of stride and window count minus one in the shared multiplier,
// and the check state puts the answer into the output register once free.
// A next command with d active axes passes a check state and then emits a
// finished item on an empty or finished walk, else d tile items (one item
// per cycle while the receiver keeps tready high) followed by the update
// states for each axis the carry walk visits. A restart acts when accepted.
// The block works on one command at a time; the next command is accepted
// once the previous one is done, even while its last item still waits in
// the output register. When the receiver stalls, the controller holds in
// its check or emit state until the output register frees up.
// Reset clears the walk, sets every axis to count 1, first 0, stride 1,
// block 1, and sets one active axis. Configuration is taken in
// any cycle. Depends on wtg_pkg, wtg_ctrl and wtg_datapath.
module window_tile_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel: active_dims.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wtg_pkg::AXIS_BITS-1:0]       cfg_data,
    // Slave stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // axis[3:0], axis_length[34:4], window_count[65:35], first_index[97:66],
    // stride[129:98], block_size[160:130], zero fill above.
    input  logic [wtg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // cmd[1:0].
    input  logic [1:0]                          s_axis_tuser,
    // Master stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // axis_out[3:0], tile_count[34:4], tile_first[65:35], tile_stride[96:66],
    // zero fill above.
    output logic [wtg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status[1:0].
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);

    wtg_pkg::ctl_t                     ctl;
    wtg_pkg::stat_t                    stat;
    logic [wtg_pkg::AXIS_BITS-1:0]     out_axis;
    logic [wtg_pkg::COORD_BITS-1:0]    out_count;
    logic [wtg_pkg::COORD_BITS-1:0]    out_first;
    logic [wtg_pkg::COORD_BITS-1:0]    out_stride;

    assign cfg_ready = 1'b1;

    // Command sequencing.
    wtg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Tables, arithmetic and output register.
    wtg_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (s_axis_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .ctl        (ctl),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_axis   (out_axis),
        .out_count  (out_count),
        .out_first  (out_first),
        .out_stride (out_stride),
        .out_last   (m_axis_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {7'b0, out_stride, out_first, out_count, out_axis};

endmodule

// File: rtl/wtg_ctrl.sv
// Controller state machine of the window tile generator.
// Sequences loads, tile emission and the axis carry walk.
// Depends on wtg_pkg.
module wtg_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_cmd,
    output logic             in_ready,
    input  wtg_pkg::stat_t   stat,
    output wtg_pkg::ctl_t    ctl
);

    wtg_pkg::state_t state_reg;
    wtg_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wtg_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    case (in_cmd)
                        wtg_pkg::CMD_LOAD:    state_next = wtg_pkg::S_LD_MUL;
                        wtg_pkg::CMD_RESTART: ctl.rewind = 1'b1;
                        wtg_pkg::CMD_NEXT:    state_next = wtg_pkg::S_NX_CHK;
                        default:              state_next = wtg_pkg::S_IDLE;
                    endcase
                end
            end
            wtg_pkg::S_LD_MUL:
            begin
                ctl.ld_mul = 1'b1;
                state_next = wtg_pkg::S_LD_CHK;
            end
            wtg_pkg::S_LD_CHK:
            begin
                if (stat.out_free)
                begin
                    ctl.ld_commit = 1'b1;
                    state_next    = wtg_pkg::S_IDLE;
                end
            end
            wtg_pkg::S_NX_CHK:
            begin
                if (!stat.walk_empty)
                begin
                    state_next = wtg_pkg::S_EMIT;
                end
                else if (stat.out_free)
                begin
                    ctl.fin_emit = 1'b1;
                    state_next   = wtg_pkg::S_IDLE;
                end
            end
            wtg_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.tile_emit = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = wtg_pkg::S_UPD_NIN;
                    end
                end
            end
            wtg_pkg::S_UPD_NIN:
            begin
                ctl.nin_load = 1'b1;
                state_next   = wtg_pkg::S_UPD_MUL;
            end
            wtg_pkg::S_UPD_MUL:
            begin
                ctl.upd_mul = 1'b1;
                state_next  = wtg_pkg::S_UPD_ADD;
            end
            wtg_pkg::S_UPD_ADD:
            begin
                ctl.upd_apply = 1'b1;
                if (stat.carry && !stat.idx_last)
                begin
                    state_next = wtg_pkg::S_UPD_NIN;
                end
                else
                begin
                    state_next = wtg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wtg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/wtg_datapath.sv
// Datapath of the window tile generator: axis tables, walk state,
// shared multiplier, load check and the output register.
// Depends on wtg_pkg.
module wtg_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [wtg_pkg::IN_DATA_W-1:0]     in_data,
    input  logic                              cfg_valid,
    input  logic [wtg_pkg::AXIS_BITS-1:0]     cfg_data,
    input  logic                              out_ready,
    input  wtg_pkg::ctl_t                     ctl,
    output wtg_pkg::stat_t                    stat,
    output logic                              out_valid,
    output logic [1:0]                        out_status,
    output logic [wtg_pkg::AXIS_BITS-1:0]     out_axis,
    output logic [wtg_pkg::COORD_BITS-1:0]    out_count,
    output logic [wtg_pkg::COORD_BITS-1:0]    out_first,
    output logic [wtg_pkg::COORD_BITS-1:0]    out_stride,
    output logic                              out_last
);

    localparam int CB = wtg_pkg::COORD_BITS;
    localparam int AB = wtg_pkg::AXIS_BITS;
    localparam int NA = wtg_pkg::MAX_AXES;
    localparam int PB = wtg_pkg::PROD_BITS;

    // Captured input item.
    logic [AB-1:0]  in_axis_reg;
    logic [CB-1:0]  len_reg;
    logic [CB-1:0]  cnt_reg;
    logic [31:0]    fst_reg;
    logic [31:0]    str_reg;
    logic [CB-1:0]  blk_reg;

    // Axis tables and walk state.
    logic [CB-1:0]  count_tab_reg  [NA];
    logic [CB-1:0]  first_tab_reg  [NA];
    logic [CB-1:0]  stride_tab_reg [NA];
    logic [CB-1:0]  block_tab_reg  [NA];
    logic [CB-1:0]  done_reg       [NA];
    logic [CB-1:0]  start_reg      [NA];
    logic           finished_reg;
    logic [AB-1:0]  idx_reg;
    logic [AB-1:0]  dims_reg;
    logic [CB-1:0]  nin_reg;
    logic [PB-1:0]  prod_reg;

    // Output register.
    logic           out_valid_reg;
    logic [1:0]     out_status_reg;
    logic [AB-1:0]  out_axis_reg;
    logic [CB-1:0]  out_count_reg;
    logic [CB-1:0]  out_first_reg;
    logic [CB-1:0]  out_stride_reg;
    logic           out_last_reg;

    logic [AB-1:0]  dims_eff;
    logic [AB-1:0]  last_idx;
    logic           idx_last;
    logic           empty;
    logic [CB-1:0]  cur_count;
    logic [CB-1:0]  cur_done;
    logic [CB-1:0]  cur_block;
    logic [CB-1:0]  cur_start;
    logic [CB-1:0]  cur_stride;
    logic [CB-1:0]  cur_first;
    logic [CB-1:0]  rem;
    logic [CB-1:0]  cur_nin;
    logic [CB:0]    done_sum;
    logic           carry;
    logic [CB-1:0]  mul_a;
    logic [CB-1:0]  mul_b;
    logic           ld_pre_ok;
    logic signed [63:0] reach;
    logic           ld_ok;
    logic           do_rewind;
    logic           out_free;

    // Effective number of active axes, clamped to one through the table depth.
    always_comb
    begin
        if (dims_reg == '0)
        begin
            dims_eff = AB'(1);
        end
        else if (dims_reg > AB'(NA))
        begin
            dims_eff = AB'(NA);
        end
        else
        begin
            dims_eff = dims_reg;
        end
    end

    assign last_idx = dims_eff - AB'(1);
    assign idx_last = (idx_reg == last_idx);

    // An active axis with a zero window count makes the walk empty.
    always_comb
    begin
        empty = 1'b0;
        for (int i = 0; i < NA; i++)
        begin
            if ((AB'(i) < dims_eff) && (count_tab_reg[i] == '0))
            begin
                empty = 1'b1;
            end
        end
    end

    // Current axis values and its tile size.
    assign cur_count  = count_tab_reg[idx_reg];
    assign cur_done   = done_reg[idx_reg];
    assign cur_block  = block_tab_reg[idx_reg];
    assign cur_start  = start_reg[idx_reg];
    assign cur_stride = stride_tab_reg[idx_reg];
    assign cur_first  = first_tab_reg[idx_reg];
    assign rem        = cur_count - cur_done;
    assign cur_nin    = (rem < cur_block) ? rem : cur_block;

    // The axis wraps when its done count reaches the window count.
    assign done_sum = {1'b0, cur_done} + {1'b0, nin_reg};
    assign carry    = (done_sum >= {1'b0, cur_count});

    // Shared multiplier operands: load reach or tile advance.
    always_comb
    begin
        if (ctl.upd_mul)
        begin
            mul_a = nin_reg;
            mul_b = cur_stride;
        end
        else
        begin
            mul_a = str_reg[CB-1:0];
            mul_b = cnt_reg - CB'(1);
        end
    end

    // Load check: last window sample must stay inside the axis.
    assign ld_pre_ok = (in_axis_reg < AB'(NA)) && !str_reg[31] && (str_reg != '0)
                       && !fst_reg[31] && (blk_reg != '0);

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            reach = $signed({33'b0, fst_reg[CB-1:0]}) - $signed({33'b0, str_reg[CB-1:0]});
        end
        else
        begin
            reach = $signed({33'b0, fst_reg[CB-1:0]}) + $signed({2'b0, prod_reg});
        end
    end

    assign ld_ok     = ld_pre_ok && (reach < $signed({33'b0, len_reg}));
    assign do_rewind = ctl.rewind || (ctl.ld_commit && ld_ok);
    assign out_free  = !out_valid_reg || out_ready;

    // Input capture, multiplier product and tile count registers.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            in_axis_reg <= in_data[3:0];
            len_reg     <= in_data[34:4];
            cnt_reg     <= in_data[65:35];
            fst_reg     <= in_data[97:66];
            str_reg     <= in_data[129:98];
            blk_reg     <= in_data[160:130];
        end
        if (ctl.ld_mul || ctl.upd_mul)
        begin
            prod_reg <= PB'(mul_a) * PB'(mul_b);
        end
        if (ctl.nin_load)
        begin
            nin_reg <= cur_nin;
        end
    end

    // Active axes register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= AB'(1);
        end
        else if (cfg_valid)
        begin
            dims_reg <= cfg_data;
        end
    end

    // Axis tables, walk state and axis counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                count_tab_reg[i]  <= CB'(1);
                first_tab_reg[i]  <= '0;
                stride_tab_reg[i] <= CB'(1);
                block_tab_reg[i]  <= CB'(1);
                done_reg[i]       <= '0;
                start_reg[i]      <= '0;
            end
            finished_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            // Accepted load writes the settings of its axis.
            if (ctl.ld_commit && ld_ok)
            begin
                count_tab_reg[in_axis_reg]  <= cnt_reg;
                first_tab_reg[in_axis_reg]  <= fst_reg[CB-1:0];
                stride_tab_reg[in_axis_reg] <= str_reg[CB-1:0];
                block_tab_reg[in_axis_reg]  <= blk_reg;
            end

            // Rewind puts every axis back at its first sample.
            if (do_rewind)
            begin
                for (int i = 0; i < NA; i++)
                begin
                    done_reg[i] <= '0;
                    if (ctl.ld_commit && (in_axis_reg == AB'(i)))
                    begin
                        start_reg[i] <= fst_reg[CB-1:0];
                    end
                    else
                    begin
                        start_reg[i] <= first_tab_reg[i];
                    end
                end
                finished_reg <= 1'b0;
            end

            // Advance the current axis or wrap it and move to the next one.
            if (ctl.upd_apply)
            begin
                if (!carry)
                begin
                    done_reg[idx_reg]  <= done_sum[CB-1:0];
                    start_reg[idx_reg] <= cur_start + prod_reg[CB-1:0];
                end
                else
                begin
                    done_reg[idx_reg]  <= '0;
                    start_reg[idx_reg] <= cur_first;
                    if (idx_last)
                    begin
                        finished_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AB'(1);
                    end
                end
            end

            if (ctl.capture)
            begin
                idx_reg <= '0;
            end
            else if (ctl.tile_emit)
            begin
                idx_reg <= idx_last ? '0 : idx_reg + AB'(1);
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.ld_commit || ctl.fin_emit || ctl.tile_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (ctl.ld_commit)
        begin
            out_status_reg <= ld_ok ? wtg_pkg::STAT_ACCEPTED : wtg_pkg::STAT_REJECTED;
            out_axis_reg   <= in_axis_reg;
            out_count_reg  <= '0;
            out_first_reg  <= '0;
            out_stride_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (ctl.fin_emit)
        begin
            out_status_reg <= wtg_pkg::STAT_FINISHED;
            out_axis_reg   <= '0;
            out_count_reg  <= '0;
            out_first_reg  <= '0;
            out_stride_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (ctl.tile_emit)
        begin
            out_status_reg <= wtg_pkg::STAT_TILE;
            out_axis_reg   <= idx_reg;
            out_count_reg  <= cur_nin;
            out_first_reg  <= cur_start;
            out_stride_reg <= cur_stride;
            out_last_reg   <= idx_last;
        end
    end

    assign stat.out_free   = out_free;
    assign stat.walk_empty = empty || finished_reg;
    assign stat.idx_last   = idx_last;
    assign stat.carry      = carry;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_axis   = out_axis_reg;
    assign out_count  = out_count_reg;
    assign out_first  = out_first_reg;
    assign out_stride = out_stride_reg;
    assign out_last   = out_last_reg;

endmodule

// File: rtl/wtg_checker.sv
// Port-level checker for the window tile generator, bound to the top level.
// Watches both streams over time.
// Depends on wtg_pkg and window_tile_generator.
module wtg_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [wtg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic [1:0]                          m_axis_tuser,
    input  logic                                m_axis_tlast
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // A load answer always ends its command and carries only its axis.
    a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == wtg_pkg::STAT_ACCEPTED ||
                          m_axis_tuser == wtg_pkg::STAT_REJECTED)
        |-> m_axis_tlast && (m_axis_tdata[96:4] == '0))
        else $error("load answer malformed");

    // A finished answer carries no tile.
    a_fin_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == wtg_pkg::STAT_FINISHED)
        |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("finished answer malformed");

    // A tile item always has a nonzero stride.
    a_tile_stride: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == wtg_pkg::STAT_TILE)
        |-> (m_axis_tdata[96:66] != '0))
        else $error("tile item with zero stride");

    // A load keeps the slave side busy in the following cycle.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == wtg_pkg::CMD_LOAD)
        |=> !s_axis_tready)
        else $error("new item taken while a load is checked");

endmodule

bind window_tile_generator wtg_checker u_wtg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/window_tile_generator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for window_tile_generator: loads, restarts and next
// commands go in on the slave stream, and every result item is checked against
// a built-in walk predictor. Depends on wtg_pkg and the window_tile_generator RTL.
module window_tile_generator_test;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Cycles the block may still be busy after its last result item.
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int ITEM_TARGET   = 500;
    localparam int WALK_STEPS    = 40;
    localparam logic [30:0] COORD_MAX = '1;

    // One command item as it travels on the slave stream.
    typedef struct {
        bit [1:0]  cmd;
        bit [3:0]  axis;
        bit [30:0] length;
        bit [30:0] count;
        bit [31:0] first;
        bit [31:0] stride;
        bit [30:0] block;
    } tile_cmd_t;

    // One result item as it travels on the master stream.
    typedef struct {
        bit [1:0]  status;
        bit [3:0]  axis;
        bit [30:0] count;
        bit [30:0] first;
        bit [30:0] stride;
        bit        last;
    } tile_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [wtg_pkg::AXIS_BITS-1:0]  cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [wtg_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [wtg_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    // Predicted state of the walk.
    bit [3:0]   dims_reg;
    bit [30:0]  cnt_tab[wtg_pkg::MAX_AXES];
    bit [30:0]  first_tab[wtg_pkg::MAX_AXES];
    bit [30:0]  stride_tab[wtg_pkg::MAX_AXES];
    bit [30:0]  block_tab[wtg_pkg::MAX_AXES];
    bit [30:0]  done_tab[wtg_pkg::MAX_AXES];
    bit [30:0]  start_tab[wtg_pkg::MAX_AXES];
    bit         walk_over;
    tile_item_t pending_answers[$];

    // Run bookkeeping.
    int  mismatches = 0;
    int  items_sent = 0;
    int  cfg_writes = 0;
    int  results_seen = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    int  cycles = 0;
    int  sink_hold = 0;
    bit  quiet_tail = 1'b0;

    window_tile_generator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycles, pending_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    // Receiver stalls in random bursts, none during the quiet tail.
    always @(posedge clk)
    begin
        if (sink_hold > 0)
            sink_hold--;
        else if (!quiet_tail && $urandom_range(0, 11) == 0)
            sink_hold = $urandom_range(1, 15);
        m_axis_tready <= (sink_hold == 0);
    end

    // ------------------------------------------------------------------
    // Walk predictor
    // ------------------------------------------------------------------

    // The register is clamped to the axes that exist.
    function automatic int active_axes();
        if (dims_reg == 0)
            return 1;
        if (int'(dims_reg) > wtg_pkg::MAX_AXES)
            return wtg_pkg::MAX_AXES;
        return int'(dims_reg);
    endfunction

    function automatic void rewind_walk();
        for (int i = 0; i < wtg_pkg::MAX_AXES; i++)
        begin
            done_tab[i]  = '0;
            start_tab[i] = first_tab[i];
        end
        walk_over = 1'b0;
    endfunction

    function automatic void reset_prediction();
        dims_reg = 4'd1;
        for (int i = 0; i < wtg_pkg::MAX_AXES; i++)
        begin
            cnt_tab[i]    = 31'd1;
            first_tab[i]  = '0;
            stride_tab[i] = 31'd1;
            block_tab[i]  = 31'd1;
        end
        rewind_walk();
    endfunction

    function automatic void queue_answer(bit [1:0] status, int axis, bit [30:0] count,
                                         bit [30:0] first, bit [30:0] stride, bit last);
        tile_item_t r;
        r.status = status;
        r.axis   = axis[3:0];
        r.count  = count;
        r.first  = first;
        r.stride = stride;
        r.last   = last;
        pending_answers.insert(pending_answers.size(), r);
    endfunction

    // True once further next commands can only answer finished.
    function automatic bit walk_ended();
        bit ended;
        ended = walk_over;
        for (int i = 0; i < active_axes(); i++)
            if (cnt_tab[i] == 0)
                ended = 1'b1;
        return ended;
    endfunction

    // Works out the result items of one accepted command and advances the walk.
    function automatic void advance_walk(tile_cmd_t c);
        longint    l;
        longint    n;
        longint    f;
        longint    s;
        longint    b;
        bit        ok;
        int        d;
        bit [30:0] rem;
        bit [30:0] nin[wtg_pkg::MAX_AXES];
        bit [63:0] step;
        case (c.cmd)
            wtg_pkg::CMD_LOAD:
            begin
                // The window end is checked in 64-bit signed arithmetic.
                l = longint'(c.length);
                n = longint'(c.count);
                f = longint'(signed'(c.first));
                s = longint'(signed'(c.stride));
                b = longint'(c.block);
                ok = (int'(c.axis) < wtg_pkg::MAX_AXES) && (s >= 1) && (f >= 0) && (b >= 1);
                if (ok && (f + s * (n - 1) > l - 1))
                    ok = 1'b0;
                if (ok)
                begin
                    cnt_tab[c.axis]    = c.count;
                    first_tab[c.axis]  = c.first[30:0];
                    stride_tab[c.axis] = c.stride[30:0];
                    block_tab[c.axis]  = c.block;
                    rewind_walk();
                end
                queue_answer(ok ? wtg_pkg::STAT_ACCEPTED : wtg_pkg::STAT_REJECTED,
                             int'(c.axis), '0, '0, '0, 1'b1);
            end
            wtg_pkg::CMD_RESTART:
            begin
                rewind_walk();
            end
            wtg_pkg::CMD_NEXT:
            begin
                if (walk_ended())
                begin
                    queue_answer(wtg_pkg::STAT_FINISHED, 0, '0, '0, '0, 1'b1);
                    return;
                end
                d = active_axes();
                for (int i = 0; i < d; i++)
                begin
                    rem    = cnt_tab[i] - done_tab[i];
                    nin[i] = (rem < block_tab[i]) ? rem : block_tab[i];
                    queue_answer(wtg_pkg::STAT_TILE, i, nin[i], start_tab[i], stride_tab[i],
                                 i == d - 1);
                end
                // Axis 0 advances first; a wrapped axis carries into the next one.
                for (int i = 0; i < d; i++)
                begin
                    done_tab[i] = done_tab[i] + nin[i];
                    if (done_tab[i] < cnt_tab[i])
                    begin
                        step = 64'(start_tab[i]) + 64'(nin[i]) * 64'(stride_tab[i]);
                        start_tab[i] = step[30:0];
                        return;
                    end
                    done_tab[i]  = '0;
                    start_tab[i] = first_tab[i];
                end
                walk_over = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Every accepted result item is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        tile_item_t got;
        tile_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tuser;
            got.axis   = m_axis_tdata[3:0];
            got.count  = m_axis_tdata[34:4];
            got.first  = m_axis_tdata[65:35];
            got.stride = m_axis_tdata[96:66];
            got.last   = m_axis_tlast;
            status_seen[got.status]++;
            if (pending_answers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, status %0d axis %0d",
                                          got.status, got.axis));
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("status", got.status, want.status);
                check_field("axis", got.axis, want.axis);
                check_field("tile_count", got.count, want.count);
                check_field("tile_first", got.first, want.first);
                check_field("tile_stride", got.stride, want.stride);
                check_field("last", got.last, want.last);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [wtg_pkg::IN_DATA_W-1:0] pack_cmd(tile_cmd_t c);
        logic [wtg_pkg::IN_DATA_W-1:0] v;
        v          = '0;
        v[3:0]     = c.axis;
        v[34:4]    = c.length;
        v[65:35]   = c.count;
        v[97:66]   = c.first;
        v[129:98]  = c.stride;
        v[160:130] = c.block;
        return v;
    endfunction

    // A command with random content in every data field.
    function automatic tile_cmd_t make_cmd(bit [1:0] cmd);
        tile_cmd_t c;
        c.cmd    = cmd;
        c.axis   = 4'($urandom);
        c.length = 31'($urandom);
        c.count  = 31'($urandom);
        c.first  = $urandom;
        c.stride = $urandom;
        c.block  = 31'($urandom);
        return c;
    endfunction

    function automatic tile_cmd_t make_load(int axis, bit [30:0] length, bit [30:0] count,
                                            bit [31:0] first, bit [31:0] stride,
                                            bit [30:0] block);
        tile_cmd_t c;
        c.cmd    = wtg_pkg::CMD_LOAD;
        c.axis   = axis[3:0];
        c.length = length;
        c.count  = count;
        c.first  = first;
        c.stride = stride;
        c.block  = block;
        return c;
    endfunction

    // A valid load with a short window so that walks run to their end.
    function automatic tile_cmd_t small_load(int axis);
        int n;
        int blk;
        int stp;
        int fst;
        n = (axis < 2) ? $urandom_range(1, 6) : $urandom_range(1, 3);
        if ($urandom_range(0, 19) == 0)
            n = 0;
        blk = $urandom_range(1, 4);
        // Higher axes mostly fit in one tile.
        if (axis >= 2 && $urandom_range(0, 3) != 0 && n > blk)
            blk = n;
        stp = $urandom_range(1, 3);
        fst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1 << 20) : $urandom_range(0, 5);
        return make_load(axis,
                         31'(fst + stp * ((n > 0) ? n - 1 : 0) + 1 + $urandom_range(0, 3)),
                         31'(n), fst, stp, 31'(blk));
    endfunction

    // Items that disturb a walk: wild loads, short valid loads, restarts and ignored commands.
    function automatic tile_cmd_t noise_item();
        tile_cmd_t c;
        case ($urandom_range(0, 4))
            0:
            begin
                c = make_cmd(wtg_pkg::CMD_LOAD);
            end
            1:
            begin
                // Plausible load with a large first index; about half pass.
                c        = make_cmd(wtg_pkg::CMD_LOAD);
                c.axis   = 4'($urandom_range(0, wtg_pkg::MAX_AXES - 1));
                c.count  = 31'($urandom_range(0, 20));
                c.stride = $urandom_range(1, 8);
                c.first  = {1'b0, c.first[30:0]};
            end
            2:
            begin
                c = make_cmd(wtg_pkg::CMD_RESTART);
            end
            3:
            begin
                c = make_cmd(CMD_UNUSED);
            end
            default:
            begin
                c = small_load($urandom_range(0, wtg_pkg::MAX_AXES - 1));
            end
        endcase
        return c;
    endfunction

    // Sends one item, with an occasional random gap ahead of it.
    task automatic send_item(input tile_cmd_t c);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_cmd(c);
        s_axis_tuser  <= c.cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_walk(c);
        if (c.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Holds off the sender until every predicted result has arrived.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_active_dims(input bit [3:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dims_reg = value;
        cfg_writes++;
    endtask

    // Loads every active axis, then steps through the tiles with some noise.
    task automatic run_walk(input int n_axes);
        int steps;
        for (int k = 0; k < n_axes; k++)
            send_item(small_load(k));
        if ($urandom_range(0, 3) == 0)
            send_item(make_cmd(wtg_pkg::CMD_RESTART));
        steps = 0;
        while (!walk_ended() && steps < WALK_STEPS)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(noise_item());
            else
                send_item(make_cmd(wtg_pkg::CMD_NEXT));
            steps++;
        end
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default settings give a one-tile walk; restart and ignored commands.
    task automatic test_reset_defaults();
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        send_item(make_cmd(wtg_pkg::CMD_RESTART));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        send_item(make_cmd(CMD_UNUSED));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
    endtask

    // Field extremes, every rejection rule and the empty window.
    task automatic test_load_checks();
        // Largest window in one tile.
        send_item(make_load(0, COORD_MAX, COORD_MAX, 0, 1, COORD_MAX));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        // Highest first index and stride.
        send_item(make_load(0, COORD_MAX, 1, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        // Stride of zero, most negative stride, negative first index, stride of minus one, empty block.
        send_item(make_load(0, 10, 2, 0, 0, 1));
        send_item(make_load(0, 10, 2, 0, 32'h8000_0000, 1));
        send_item(make_load(0, 10, 2, 32'hFFFF_FFFF, 1, 1));
        send_item(make_load(0, 10, 2, 0, 32'hFFFF_FFFF, 1));
        send_item(make_load(0, 10, 2, 0, 1, 0));
        // Window end one past the data, then exactly on its last sample.
        send_item(make_load(0, 10, 4, 1, 3, 1));
        send_item(make_load(0, 10, 4, 0, 3, 1));
        // Window end far beyond 31 bits.
        send_item(make_load(0, COORD_MAX, COORD_MAX, 0, 32'h7FFF_FFFF, COORD_MAX));
        // Axes that do not exist.
        send_item(make_load(wtg_pkg::MAX_AXES, 10, 2, 0, 1, 1));
        send_item(make_load(15, COORD_MAX, COORD_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            COORD_MAX));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        // Zero window count makes the walk empty.
        send_item(make_load(0, 5, 0, 0, 1, 1));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
    endtask

    // Clamping of the axis count, full-width walks, inactive empty axes.
    task automatic test_axis_config();
        set_active_dims(4'd0);
        run_walk(active_axes());
        set_active_dims(4'd15);
        run_walk(active_axes());
        set_active_dims(4'(wtg_pkg::MAX_AXES));
        run_walk(active_axes());
        // An empty axis only matters while it is active.
        set_active_dims(4'd2);
        send_item(make_load(0, 8, 3, 1, 2, 2));
        send_item(make_load(1, 5, 0, 0, 1, 1));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        set_active_dims(4'd1);
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
        send_item(make_cmd(wtg_pkg::CMD_NEXT));
    endtask

    // Random walks under random axis counts and idling on both sides.
    task automatic test_random_walks();
        while (items_sent < ITEM_TARGET - 80)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       set_active_dims(4'($urandom_range(10, 15)));
                    1:       set_active_dims(4'd0);
                    default: set_active_dims(4'($urandom_range(1, wtg_pkg::MAX_AXES)));
                endcase
            end
            run_walk(active_axes());
        end
    endtask

    // Back-to-back walks with no idling at all.
    task automatic test_quiet_tail();
        quiet_tail = 1'b1;
        while (items_sent < ITEM_TARGET)
            run_walk(active_axes());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = wtg_pkg::CMD_LOAD;
        m_axis_tready = 1'b0;
        reset_prediction();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_load_checks();
        test_axis_config();
        test_random_walks();
        test_quiet_tail();
        wait_idle();

        $display("covered %0d commands and %0d axis-count writes in %0d cycles",
                 items_sent, cfg_writes, cycles);
        $display("checked %0d tile items, %0d finished, %0d loads accepted, %0d rejected",
                 status_seen[wtg_pkg::STAT_TILE], status_seen[wtg_pkg::STAT_FINISHED],
                 status_seen[wtg_pkg::STAT_ACCEPTED], status_seen[wtg_pkg::STAT_REJECTED]);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
